// ===== rtl/core/fpa_pkg.sv =====
`timescale 1ns / 1ps

package fpa_pkg;

    // Word format: signed WORD_BITS with FRACTION_BITS fraction bits.
    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 8;

    // Divider geometry: the scaled dividend has WORD_BITS + FRACTION_BITS bits,
    // and each divider stage retires two quotient bits.
    localparam int QUO_BITS   = WORD_BITS + FRACTION_BITS;
    localparam int DIV_STAGES = (QUO_BITS + 1) / 2;
    localparam int NUM_BITS   = 2 * DIV_STAGES;

    // Width that holds any unsaturated magnitude (product or rounded quotient).
    localparam int MAG_BITS = (2 * WORD_BITS > NUM_BITS + 1) ? 2 * WORD_BITS : NUM_BITS + 1;

    // Result queue depth covers the whole pipeline so issue never stalls at full rate.
    localparam int OUT_AW    = $clog2(DIV_STAGES + 4);
    localparam int OUT_DEPTH = 1 << OUT_AW;

    localparam logic [WORD_BITS-1:0] SIGN_BIT = WORD_BITS'(1) << (WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] MAX_POS  = SIGN_BIT - 1'b1;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MAX      = 4'd10,
        OP_MIN      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } op_t;

    typedef struct packed {
        op_t                         operation;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result;
        logic                        compare_true;
        logic                        overflow;
        logic                        divide_by_zero;
    } out_word_t;

    // Classified item as it waits between the front and the back.
    typedef struct packed {
        op_t                  op;
        logic                 neg;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic [WORD_BITS-1:0] a_mag;
        logic [WORD_BITS-1:0] b_mag;
    } cls_t;

    // Payload of one back-end pipeline slot.
    typedef struct packed {
        op_t                  op;
        logic                 neg;
        logic                 dz;
        logic                 cmp;
        logic                 ovf;
        logic [WORD_BITS-1:0] res;
        logic [MAG_BITS-1:0]  mag;
        logic [WORD_BITS-1:0] rem;
        logic [NUM_BITS-1:0]  num;
        logic [NUM_BITS-1:0]  quo;
        logic [WORD_BITS-1:0] dmag;
    } slot_t;

    // Absolute value of a signed word; the most negative value maps to 2^(W-1).
    function automatic logic [WORD_BITS-1:0] word_mag(input logic [WORD_BITS-1:0] x);
        return x[WORD_BITS-1] ? (~x + 1'b1) : x;
    endfunction

    // Clamp a sign and magnitude into the word range; returns {overflow, word}.
    function automatic logic [WORD_BITS:0] sat_mag(input logic neg,
                                                   input logic [MAG_BITS-1:0] mag);
        logic [MAG_BITS-1:0]  limit;
        logic [WORD_BITS-1:0] low;
        limit = neg ? MAG_BITS'(SIGN_BIT) : MAG_BITS'(MAX_POS);
        low   = mag[WORD_BITS-1:0];
        if (mag > limit)
            return {1'b1, limit[WORD_BITS-1:0]};
        return {1'b0, neg ? (~low + 1'b1) : low};
    endfunction

endpackage

// ===== rtl/core/fpa_front.sv =====
`timescale 1ns / 1ps

module fpa_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fpa_pkg::in_word_t request,
    output logic            full,
    input  logic            deq,
    output logic            head_valid,
    output fpa_pkg::cls_t   head
);
    import fpa_pkg::*;

    localparam int FQ_AW    = 2;
    localparam int FQ_DEPTH = 1 << FQ_AW;

    cls_t               q_mem [FQ_DEPTH];
    logic [FQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FQ_AW:0]     count_reg, count_next;
    cls_t               cls;
    logic               enq;

    // Classify the incoming word: magnitudes and result sign.
    always_comb
    begin
        cls.op    = request.operation;
        cls.a     = request.operand_a;
        cls.b     = request.operand_b;
        cls.a_mag = word_mag(request.operand_a);
        cls.b_mag = word_mag(request.operand_b);
        if (request.operation == OP_FROM_INT)
            cls.neg = request.operand_a[WORD_BITS-1];
        else
            cls.neg = request.operand_a[WORD_BITS-1] ^ request.operand_b[WORD_BITS-1];
    end

    assign full       = (count_reg == (FQ_AW+1)'(FQ_DEPTH));
    assign enq        = push && !full;
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (FQ_AW)'(enq);
        rd_ptr_next = rd_ptr_reg + (FQ_AW)'(deq);
        count_next  = count_reg + (FQ_AW+1)'(enq) - (FQ_AW+1)'(deq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (enq)
            q_mem[wr_ptr_reg] <= cls;
    end

endmodule

// ===== rtl/core/fpa_back.sv =====
`timescale 1ns / 1ps

module fpa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  fpa_pkg::cls_t      head,
    output logic               deq,
    input  logic               pop_done,
    output logic               wr_en,
    output fpa_pkg::out_word_t wr_word
);
    import fpa_pkg::*;

    localparam logic [MAG_BITS-1:0] HALF = (MAG_BITS'(1) << FRACTION_BITS) >> 1;

    slot_t              slot_reg  [DIV_STAGES+1];
    slot_t              slot_next [DIV_STAGES+1];
    slot_t              issue_slot;
    logic               vld_reg   [DIV_STAGES+1];
    logic [OUT_AW:0]    pending_reg, pending_next;

    // Issue while the result queue has room for everything in flight.
    assign deq = head_valid && (pending_reg < (OUT_AW+1)'(OUT_DEPTH));

    always_comb
    begin
        pending_next = pending_reg + (OUT_AW+1)'(deq) - (OUT_AW+1)'(pop_done);
    end

    // First stage: simple operations finish here; multiply, divide and integer-to-fixed conversion are set up.
    always_comb
    begin
        logic [WORD_BITS-1:0]   s;
        logic                   gt;
        logic                   lt;
        logic [2*WORD_BITS-1:0] prod;
        slot_t                  t;
        s    = '0;
        gt   = (head.a ^ SIGN_BIT) > (head.b ^ SIGN_BIT);
        lt   = (head.a ^ SIGN_BIT) < (head.b ^ SIGN_BIT);
        prod = head.a_mag * head.b_mag;
        t.op   = head.op;
        t.neg  = head.neg;
        t.dz   = 1'b0;
        t.cmp  = 1'b0;
        t.ovf  = 1'b0;
        t.res  = '0;
        t.mag  = '0;
        t.rem  = '0;
        t.num  = NUM_BITS'(head.a_mag) << FRACTION_BITS;
        t.quo  = '0;
        t.dmag = head.b_mag;
        unique case (head.op)
            OP_ADD, OP_INC:
            begin
                s = head.a + ((head.op == OP_INC) ? WORD_BITS'(1) : head.b);
                t.ovf = ((head.a ^ s) & (((head.op == OP_INC) ? WORD_BITS'(1) : head.b) ^ s)
                         & SIGN_BIT) != '0;
                t.res = t.ovf ? (head.a[WORD_BITS-1] ? SIGN_BIT : MAX_POS) : s;
            end
            OP_SUB, OP_DEC:
            begin
                s = head.a - ((head.op == OP_DEC) ? WORD_BITS'(1) : head.b);
                t.ovf = ((head.a ^ ((head.op == OP_DEC) ? WORD_BITS'(1) : head.b))
                         & (head.a ^ s) & SIGN_BIT) != '0;
                t.res = t.ovf ? (head.a[WORD_BITS-1] ? SIGN_BIT : MAX_POS) : s;
            end
            OP_MUL:      t.mag = MAG_BITS'(prod);
            OP_DIV:      t.dz  = (head.b == '0);
            OP_GT:       t.cmp = gt;
            OP_LT:       t.cmp = lt;
            OP_GE:       t.cmp = !lt;
            OP_LE:       t.cmp = !gt;
            OP_EQ:       t.cmp = (head.a == head.b);
            OP_NE:       t.cmp = (head.a != head.b);
            OP_MAX:      t.res = gt ? head.a : head.b;
            OP_MIN:      t.res = lt ? head.a : head.b;
            OP_FROM_INT: t.mag = MAG_BITS'(head.a_mag) << FRACTION_BITS;
            OP_TO_INT:   t.res = WORD_BITS'($signed(head.a) >>> FRACTION_BITS);
            default:     t.res = '0;
        endcase
        issue_slot = t;
    end

    // Divider stages, two restoring steps each; the product is rounded in the first.
    always_comb
    begin
        slot_t              t;
        logic [WORD_BITS:0] r;
        slot_next[0] = issue_slot;
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            t = slot_reg[k-1];
            if (k == 1 && t.op == OP_MUL)
                t.mag = (t.mag + HALF) >> FRACTION_BITS;
            for (int j = 0; j < 2; j++)
            begin
                r     = {t.rem, t.num[NUM_BITS-1]};
                t.num = t.num << 1;
                t.quo = t.quo << 1;
                if (r >= {1'b0, t.dmag})
                begin
                    r        = r - {1'b0, t.dmag};
                    t.quo[0] = 1'b1;
                end
                t.rem = r[WORD_BITS-1:0];
            end
            slot_next[k] = t;
        end
    end

    // Final selection: round the quotient and saturate magnitudes.
    always_comb
    begin
        slot_t                t;
        logic                 rnd;
        logic [MAG_BITS-1:0]  qmag;
        logic [WORD_BITS:0]   sat;
        t    = slot_reg[DIV_STAGES];
        rnd  = {t.rem, 1'b0} >= {1'b0, t.dmag};
        qmag = MAG_BITS'(t.quo) + MAG_BITS'(rnd);
        sat  = sat_mag(t.neg, (t.op == OP_DIV) ? qmag : t.mag);
        wr_word.compare_true   = t.cmp;
        wr_word.divide_by_zero = 1'b0;
        unique case (t.op) inside
            OP_MUL, OP_FROM_INT:
            begin
                wr_word.result   = sat[WORD_BITS-1:0];
                wr_word.overflow = sat[WORD_BITS];
            end
            OP_DIV:
            begin
                wr_word.result         = t.dz ? '0 : sat[WORD_BITS-1:0];
                wr_word.overflow       = t.dz ? 1'b0 : sat[WORD_BITS];
                wr_word.divide_by_zero = t.dz;
            end
            default:
            begin
                wr_word.result   = t.res;
                wr_word.overflow = t.ovf;
            end
        endcase
    end

    assign wr_en = vld_reg[DIV_STAGES];

    // Valid bits and the credit count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
                vld_reg[k] <= 1'b0;
            pending_reg <= '0;
        end
        else
        begin
            vld_reg[0] <= deq;
            for (int k = 1; k <= DIV_STAGES; k++)
                vld_reg[k] <= vld_reg[k-1];
            pending_reg <= pending_next;
        end
    end

    // Slot payload advances every cycle.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_STAGES; k++)
            slot_reg[k] <= slot_next[k];
    end

endmodule

// ===== rtl/core/fpa_outq.sv =====
`timescale 1ns / 1ps

module fpa_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  fpa_pkg::out_word_t wr_word,
    input  logic               pop,
    output logic               empty,
    output logic               pop_done,
    output fpa_pkg::out_word_t response
);
    import fpa_pkg::*;

    out_word_t          mem [OUT_DEPTH];
    logic [OUT_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OUT_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OUT_AW:0]    count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign pop_done = pop && !empty;
    assign response = mem[rd_ptr_reg];

    // Pointers and fill count; the back end never writes past capacity.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (OUT_AW)'(wr_en);
        rd_ptr_next = rd_ptr_reg + (OUT_AW)'(pop_done);
        count_next  = count_reg + (OUT_AW+1)'(wr_en) - (OUT_AW+1)'(pop_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_word;
    end

endmodule

// ===== rtl/core/fixed_point_q24_8_alu.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Word
// input     push / full            request  (operation, operand_a, operand_b)
// result    pop / empty            response (result, compare_true, overflow, divide_by_zero)
//
// One word is accepted per cycle unless full; one result can leave per cycle unless empty.
// Each word passes through the issue stage and the divider stages, sized for Q24.8,
// that retire two quotient bits per stage, and then through the result queue.
// Results leave in input order; a stalled result side fills the result queue and
// then the input queue, after which full rises. Reset empties both queues.
module fixed_point_q24_8_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  fpa_pkg::in_word_t  request,
    input  logic               pop,
    output logic               empty,
    output fpa_pkg::out_word_t response
);
    import fpa_pkg::*;

    logic      head_valid;
    cls_t      head;
    logic      deq;
    logic      pop_done;
    logic      wr_en;
    out_word_t wr_word;

    // Front end: classify and queue.
    fpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .request    (request),
        .full       (full),
        .deq        (deq),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end: execute pipeline with divider.
    fpa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .deq        (deq),
        .pop_done   (pop_done),
        .wr_en      (wr_en),
        .wr_word    (wr_word)
    );

    // Result queue.
    fpa_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_word  (wr_word),
        .pop      (pop),
        .empty    (empty),
        .pop_done (pop_done),
        .response (response)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import fpa_pkg::*;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    in_word_t request;
    logic pop;
    logic empty;
    out_word_t response;

    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
    localparam int LIMIT_CYCLES = 400000;

    out_word_t alu_expected[$];
    int errors;
    int cycles;
    bit idle_enable;
    bit hold_results;

    fixed_point_q24_8_alu DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .request(request),
        .pop(pop), .empty(empty), .response(response)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Clamp a sign and a wide magnitude into the word range.
    function automatic logic [32:0] clamp_mag(input logic neg, input logic [127:0] mag);
        if (!neg && mag > 128'h7FFF_FFFF)
        begin
            return {1'b1, W_MAX};
        end
        if (neg && mag > 128'h8000_0000)
        begin
            return {1'b1, W_MIN};
        end
        return {1'b0, neg ? (~mag[31:0] + 32'd1) : mag[31:0]};
    endfunction

    // Compute the expected result word of one request.
    function automatic out_word_t alu_predict(input in_word_t req);
        out_word_t o;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] s;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [127:0] wide;
        logic [127:0] q;
        logic [127:0] r;
        logic [32:0] cl;
        logic neg;
        ua = req.operand_a;
        ub = req.operand_b;
        ma = ua[31] ? (~ua + 32'd1) : ua;
        mb = ub[31] ? (~ub + 32'd1) : ub;
        neg = ua[31] ^ ub[31];
        o = '0;
        case (req.operation)
            OP_ADD, OP_INC:
            begin
                if (req.operation == OP_INC)
                begin
                    ub = 32'd1;
                end
                s = ua + ub;
                if ((ua ^ s) & (ub ^ s) & W_MIN)
                begin
                    o.overflow = 1'b1;
                    s = ua[31] ? W_MIN : W_MAX;
                end
                o.result = s;
            end
            OP_SUB, OP_DEC:
            begin
                if (req.operation == OP_DEC)
                begin
                    ub = 32'd1;
                end
                s = ua - ub;
                if ((ua ^ ub) & (ua ^ s) & W_MIN)
                begin
                    o.overflow = 1'b1;
                    s = ua[31] ? W_MIN : W_MAX;
                end
                o.result = s;
            end
            OP_MUL:
            begin
                wide = (128'(ma) * 128'(mb) + 128'd128) >> 8;
                cl = clamp_mag(neg, wide);
                {o.overflow, o.result} = cl;
            end
            OP_DIV:
            begin
                if (ub == 32'd0)
                begin
                    o.divide_by_zero = 1'b1;
                end
                else
                begin
                    wide = 128'(ma) << 8;
                    q = wide / 128'(mb);
                    r = wide % 128'(mb);
                    if (r >= 128'(mb) - r)
                    begin
                        q = q + 128'd1;
                    end
                    cl = clamp_mag(neg, q);
                    {o.overflow, o.result} = cl;
                end
            end
            OP_GT: o.compare_true = $signed(ua) > $signed(ub);
            OP_LT: o.compare_true = $signed(ua) < $signed(ub);
            OP_GE: o.compare_true = $signed(ua) >= $signed(ub);
            OP_LE: o.compare_true = $signed(ua) <= $signed(ub);
            OP_EQ: o.compare_true = ua == ub;
            OP_NE: o.compare_true = ua != ub;
            OP_MAX: o.result = ($signed(ua) > $signed(ub)) ? ua : ub;
            OP_MIN: o.result = ($signed(ua) < $signed(ub)) ? ua : ub;
            OP_FROM_INT:
            begin
                cl = clamp_mag(ua[31], 128'(ma) << 8);
                {o.overflow, o.result} = cl;
            end
            default: o.result = $signed(ua) >>> 8;
        endcase
        return o;
    endfunction

    // Send one request word, with random idle bursts before it while idle_enable is set.
    task automatic send_word(input op_t op, input logic [31:0] a, input logic [31:0] b);
        in_word_t w;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        w.operation = op;
        w.operand_a = a;
        w.operand_b = b;
        request <= w;
        push <= 1'b1;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        alu_expected.push_back(alu_predict(w));
        @(negedge clk);
    endtask

    // Random operand biased toward interesting values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return W_MAX;
            1: return W_MIN;
            2: return 32'(int'($urandom_range(0, 6)) - 3);
            3: return 32'($urandom_range(0, 4095)) - 32'd2048;
            4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        op_t op;
        send_word(OP_ADD, W_MAX, 32'd1);
        send_word(OP_ADD, W_MIN, W_MIN);
        send_word(OP_SUB, W_MIN, 32'd1);
        send_word(OP_SUB, W_MAX, W_MIN);
        send_word(OP_MUL, W_MAX, W_MAX);
        send_word(OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
        send_word(OP_MUL, 32'h0000_0001, 32'h0000_0080);
        send_word(OP_DIV, 32'h0000_0100, 32'd0);
        send_word(OP_DIV, W_MIN, 32'hFFFF_FFFF);
        send_word(OP_DIV, 32'h0000_0100, 32'h0000_0300);
        send_word(OP_DIV, 32'hFFFF_FF00, 32'h0000_0200);
        send_word(OP_INC, W_MAX, 32'd0);
        send_word(OP_DEC, W_MIN, 32'd0);
        send_word(OP_FROM_INT, 32'h0080_0000, 32'd0);
        send_word(OP_FROM_INT, 32'hFF80_0000, 32'd0);
        send_word(OP_TO_INT, 32'hFFFF_FF01, 32'd0);
        send_word(OP_MAX, 32'd5, 32'd5);
        send_word(OP_MIN, W_MIN, W_MAX);
        // Each comparison on equal and unequal operands.
        for (int i = 4; i <= 9; i++)
        begin
            op = op_t'(i);
            send_word(op, 32'hFFFF_FFFF, 32'd1);
            send_word(op, 32'd7, 32'd7);
        end
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_word(op_t'($urandom_range(0, 15)), pick_operand(),
                ($urandom_range(0, 7) == 0) ? 32'd0 : pick_operand());
        end
    endtask

    // Receiver stops for a long stretch while the sender keeps pushing.
    task automatic test_backpressure();
        hold_results = 1'b1;
        fork
            begin
                repeat (200) @(negedge clk);
                hold_results = 1'b0;
            end
            test_random(80);
        join
    endtask

    // Result side: random pop stalls, compare each accepted word.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                pop <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge clk);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        if (rst_n && pop && !empty)
        begin
            if (alu_expected.size() == 0)
            begin
                $error("unexpected result word %h", response);
                errors++;
            end
            else
            begin
                if (response.result !== alu_expected[0].result)
                begin
                    $error("result: expected %h actual %h",
                        alu_expected[0].result, response.result);
                    errors++;
                end
                if (response.compare_true !== alu_expected[0].compare_true)
                begin
                    $error("compare_true: expected %b actual %b",
                        alu_expected[0].compare_true, response.compare_true);
                    errors++;
                end
                if (response.overflow !== alu_expected[0].overflow)
                begin
                    $error("overflow: expected %b actual %b",
                        alu_expected[0].overflow, response.overflow);
                    errors++;
                end
                if (response.divide_by_zero !== alu_expected[0].divide_by_zero)
                begin
                    $error("divide_by_zero: expected %b actual %b",
                        alu_expected[0].divide_by_zero, response.divide_by_zero);
                    errors++;
                end
                void'(alu_expected.pop_front());
            end
        end
    end

    // Main sequence.
    initial
    begin
        errors = 0;
        cycles = 0;
        idle_enable = 1'b1;
        hold_results = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        request = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(400);
        test_backpressure();
        test_random(250);
        // Last part runs without idling on either side.
        idle_enable = 1'b0;
        test_random(120);
        push <= 1'b0;
        while (alu_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
        if (errors == 0 && alu_expected.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
